// ===== rtl/spr_pkg.sv =====
// shared constants, types and helpers of the signed permutation rounder
package spr_pkg;

    localparam int MAX_DIM      = 64;
    localparam int ELEMENT_BITS = 16;
    localparam int COL_BITS     = $clog2(MAX_DIM);
    localparam int CNT_BITS     = $clog2(MAX_DIM + 1);
    localparam int ADDR_BITS    = 3;
    localparam int DATA_BITS    = 32;

    // register map, index of each configuration register
    typedef enum logic {
        REG_ROW_COUNT = 1'b0,
        REG_COL_COUNT = 1'b1
    } t_reg_index;

    typedef logic [COL_BITS-1:0]     t_col;
    typedef logic [CNT_BITS-1:0]     t_count;
    typedef logic [ELEMENT_BITS-1:0] t_magnitude;

    // count of zero acts as one, anything above the maximum acts as the maximum
    function automatic t_count clamp_count(input t_count value);
        t_count result;
        if (value == '0) begin
            result = t_count'(1);
        end else if (value > t_count'(MAX_DIM)) begin
            result = t_count'(MAX_DIM);
        end else begin
            result = value;
        end
        return result;
    endfunction

endpackage

// ===== rtl/spr_elem_if.sv =====
// element channel: one matrix element per item
interface spr_elem_if;
    import spr_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [ELEMENT_BITS-1:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

// ===== rtl/spr_result_if.sv =====
// result channel: one row summary per item
interface spr_result_if;
    import spr_pkg::*;

    logic                valid;
    logic                ready;
    logic [COL_BITS-1:0] row_number;
    logic [COL_BITS-1:0] chosen_column;
    logic                chosen_negative;
    logic                row_nonzero;
    logic                is_signed_permutation;
    logic                final_row;

    modport source (
        output valid, output row_number, output chosen_column, output chosen_negative,
        output row_nonzero, output is_signed_permutation, output final_row,
        input ready
    );
    modport sink (
        input valid, input row_number, input chosen_column, input chosen_negative,
        input row_nonzero, input is_signed_permutation, input final_row,
        output ready
    );
endinterface

// ===== rtl/signed_permutation_rounder.sv =====
// top level of the signed permutation rounder: row scan, column bitmap and result register
//
// Usage: matrix elements arrive on i_elem in row-major order, one per item.
// At the last element of each row one result item leaves on o_result: the
// row number, the column of the first element of largest magnitude, its sign,
// whether the row held any nonzero element, and on the matrix's last row
// whether the matrix rounds to a signed permutation (final_row marks it).
// Rows and columns per matrix are set over the APB port: register 0 at
// address 0 holds the row count, register 1 at address 4 the column count,
// both reset to 64; write them only while the block is idle.
// The last element of a row passes through the input register and its result
// is then registered in the result register, where the receiver takes it.
// Throughput: one element per cycle while no row-ending element waits on a
// stalled receiver, set by the single compare and bitmap test between the
// input register and the result register.
// Reset (synchronous, active low) empties both registers and starts a new
// matrix at row 0, column 0. When the receiver stalls, the result waits in
// the result register; elements that end no row still flow, and an element
// that ends a row waits in the input register until the result is taken.
module signed_permutation_rounder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    spr_elem_if.sink                      i_elem,
    spr_result_if.source                  o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [spr_pkg::ADDR_BITS-1:0] paddr,
    input  logic [spr_pkg::DATA_BITS-1:0] pwdata,
    output logic [spr_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready
);
    import spr_pkg::*;

    // configuration registers
    t_count r_row_cnt;
    t_count r_col_cnt;

    // input register
    logic                   r_in_valid;
    logic [ELEMENT_BITS-1:0] r_in_elem;

    // scan state
    t_col        r_col_pos;
    t_col        r_row_pos;
    t_magnitude  r_best_mag;
    t_col        r_best_col;
    logic        r_best_neg;
    logic        r_row_nz;
    logic [MAX_DIM-1:0] r_taken;
    logic        r_perm;

    // result register
    logic  r_out_valid;
    t_col  r_out_row;
    t_col  r_out_col;
    logic  r_out_neg;
    logic  r_out_nz;
    logic  r_out_perm;
    logic  r_out_final;

    logic        cfg_write;
    t_reg_index  reg_sel;
    logic        elem_neg;
    t_magnitude  elem_mag;
    logic        take;
    t_magnitude  n_best_mag;
    t_col        n_best_col;
    logic        n_best_neg;
    logic        n_row_nz;
    t_count      cols;
    t_count      rows;
    logic        end_of_row;
    logic        last_row;
    logic        col_dup;
    logic        n_perm;
    logic        go;

    // apb register access
    assign pready    = 1'b1;
    assign reg_sel   = t_reg_index'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        case (reg_sel)
            REG_ROW_COUNT: prdata[CNT_BITS-1:0] = r_row_cnt;
            REG_COL_COUNT: prdata[CNT_BITS-1:0] = r_col_cnt;
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= t_count'(MAX_DIM);
            r_col_cnt <= t_count'(MAX_DIM);
        end else if (cfg_write) begin
            case (reg_sel)
                REG_ROW_COUNT: r_row_cnt <= pwdata[CNT_BITS-1:0];
                REG_COL_COUNT: r_col_cnt <= pwdata[CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // magnitude of the registered element, most negative value held exactly
    assign elem_neg = r_in_elem[ELEMENT_BITS-1];
    assign elem_mag = elem_neg ? (~r_in_elem + t_magnitude'(1)) : r_in_elem;
    assign take     = elem_mag > r_best_mag;

    // best element so far, including this one; strictly larger wins
    assign n_best_mag = take ? elem_mag : r_best_mag;
    assign n_best_col = take ? r_col_pos : r_best_col;
    assign n_best_neg = take ? elem_neg : r_best_neg;
    assign n_row_nz   = take || r_row_nz;

    // row and matrix boundaries
    assign cols       = clamp_count(r_col_cnt);
    assign rows       = clamp_count(r_row_cnt);
    assign end_of_row = ({1'b0, r_col_pos} + t_count'(1)) >= cols;
    assign last_row   = ({1'b0, r_row_pos} + t_count'(1)) >= rows;

    // column already chosen by an earlier row
    assign col_dup = r_taken[n_best_col];
    assign n_perm  = r_perm && n_row_nz && !col_dup;

    // an item moves on unless it ends a row and the result register is blocked
    assign go           = r_in_valid && (!end_of_row || !r_out_valid || o_result.ready);
    assign i_elem.ready = !r_in_valid || go;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_elem.ready) begin
            r_in_valid <= i_elem.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_elem.valid && i_elem.ready) begin
            r_in_elem <= i_elem.element_value;
        end
    end

    // row scan and column bitmap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos  <= '0;
            r_row_pos  <= '0;
            r_best_mag <= '0;
            r_best_col <= '0;
            r_best_neg <= 1'b0;
            r_row_nz   <= 1'b0;
            r_taken    <= '0;
            r_perm     <= 1'b1;
        end else if (go) begin
            if (!end_of_row) begin
                r_col_pos  <= r_col_pos + t_col'(1);
                r_best_mag <= n_best_mag;
                r_best_col <= n_best_col;
                r_best_neg <= n_best_neg;
                r_row_nz   <= n_row_nz;
            end else begin
                r_col_pos  <= '0;
                r_best_mag <= '0;
                r_best_col <= '0;
                r_best_neg <= 1'b0;
                r_row_nz   <= 1'b0;
                if (last_row) begin
                    r_row_pos <= '0;
                    r_taken   <= '0;
                    r_perm    <= 1'b1;
                end else begin
                    r_row_pos <= r_row_pos + t_col'(1);
                    r_perm    <= n_perm;
                    if (n_row_nz) begin
                        r_taken[n_best_col] <= 1'b1;
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && end_of_row) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && end_of_row) begin
            r_out_row   <= r_row_pos;
            r_out_col   <= n_row_nz ? n_best_col : '0;
            r_out_neg   <= n_row_nz && n_best_neg;
            r_out_nz    <= n_row_nz;
            r_out_perm  <= last_row && n_perm;
            r_out_final <= last_row;
        end
    end

    assign o_result.valid                 = r_out_valid;
    assign o_result.row_number            = r_out_row;
    assign o_result.chosen_column         = r_out_col;
    assign o_result.chosen_negative       = r_out_neg;
    assign o_result.row_nonzero           = r_out_nz;
    assign o_result.is_signed_permutation = r_out_perm;
    assign o_result.final_row             = r_out_final;

`ifndef SYNTH
    // a waiting result is never overwritten
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |-> !(go && end_of_row))
        else $error("result register overwritten while stalled");

    // permutation flag only on the last row of a matrix
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.is_signed_permutation) |-> o_result.final_row)
        else $error("permutation flag outside the final row");

    // a signed permutation needs a nonzero last row
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.is_signed_permutation) |-> o_result.row_nonzero)
        else $error("permutation flag on an empty row");

    // an empty row reports column zero and positive sign
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.row_nonzero)
            |-> (o_result.chosen_column == '0 && !o_result.chosen_negative))
        else $error("empty row with a chosen column or sign");

    // a row ending clears the scan for the next row
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && end_of_row) |=> (r_col_pos == '0 && !r_row_nz && r_best_mag == '0))
        else $error("row scan not cleared after end of row");
`endif

endmodule
